// ----- src/flash_journal_slot_manager_unit_macros.svh -----
// Assertion macros used by the top level of the flash journal slot manager.
`ifndef FLASH_JOURNAL_SLOT_MANAGER_UNIT_MACROS_SVH
`define FLASH_JOURNAL_SLOT_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FJSM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FJSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/fjsm_pkg.sv -----
// Package with constants, codes and types of the flash journal slot manager.
`default_nettype none
package fjsm_pkg;

   localparam int DEFAULT_SLOT_COUNT = 16;
   localparam int OP_W      = 3;
   localparam int CMD_W     = 2;
   localparam int SLOT_W    = 4;
   localparam int SEQ_W     = 32;
   localparam int MAGIC_W   = 32;
   localparam int MS_W      = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 32;

   localparam logic [SEQ_W-1:0]   EMPTY_SEQ      = 32'hFFFF_FFFF;
   localparam logic [MS_W-1:0]    MS_MAX         = 16'hFFFF;
   localparam logic [MS_W-1:0]    RESET_DEBOUNCE = 16'd5000;
   localparam logic [MAGIC_W-1:0] RESET_MAGIC    = 32'h4743_5052;

   typedef enum logic [OP_W-1:0] {
      OP_INIT       = 3'd0,
      OP_SCAN       = 3'd1,
      OP_TICK       = 3'd2,
      OP_SAVE_REQ   = 3'd3,
      OP_SAVE_NOW   = 3'd4,
      OP_DISCONNECT = 3'd5,
      OP_LOAD       = 3'd6
   } opcode_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE    = 2'd0,
      CMD_ERASE   = 2'd1,
      CMD_PROGRAM = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_MAGIC    = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SLOT_W-1:0] target_slot;
      logic [SEQ_W-1:0]  write_sequence;
      logic              newest_found;
      logic [SLOT_W-1:0] recent_slot;
      logic              write_pending;
      logic              last;
   } rsp_type;

   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } batch_type;

endpackage
`default_nettype wire

// ----- src/fjsm_core.sv -----
// Slot bitmap, newest record, sequence and debounce state with per-transaction update logic.
`default_nettype none
module fjsm_core #(
   parameter int SLOT_COUNT = fjsm_pkg::DEFAULT_SLOT_COUNT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic [fjsm_pkg::OP_W-1:0]     opcode,
   input  wire logic                          link_active,
   input  wire logic [fjsm_pkg::SLOT_W-1:0]   scan_slot,
   input  wire logic [fjsm_pkg::MAGIC_W-1:0]  header_magic,
   input  wire logic [fjsm_pkg::SEQ_W-1:0]    header_sequence,
   input  wire logic                          csr_write_enable,
   input  wire logic [fjsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fjsm_pkg::CSR_W-1:0]    csr_write_data,
   output fjsm_pkg::batch_type                batch
);
   import fjsm_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);

   logic [SLOT_COUNT-1:0] slot_used_ff, slot_used_in;
   logic                  newest_valid_ff, newest_valid_in;
   logic [IDX_W-1:0]      newest_index_ff, newest_index_in;
   logic [SEQ_W-1:0]      newest_seq_ff, newest_seq_in;
   logic [SEQ_W-1:0]      current_seq_ff, current_seq_in;
   logic                  save_waiting_ff, save_waiting_in;
   logic                  erase_waiting_ff, erase_waiting_in;
   logic [MS_W-1:0]       elapsed_ms_ff, elapsed_ms_in;
   logic [MS_W-1:0]       debounce_ms_ff, debounce_ms_in;
   logic [MAGIC_W-1:0]    valid_magic_ff, valid_magic_in;

   function automatic logic take_newest(input logic nv, input logic [IDX_W-1:0] ni,
                                        input logic [SEQ_W-1:0] ns,
                                        input logic [IDX_W-1:0] s,
                                        input logic [SEQ_W-1:0] q);
      return !nv || (q > ns) || ((q == ns) && (s < ni));
   endfunction

   function automatic rsp_type make_rsp(input cmd_type c, input logic [IDX_W-1:0] s,
                                        input logic [SEQ_W-1:0] q, input logic nv,
                                        input logic [IDX_W-1:0] ni, input logic pend);
      rsp_type r;
      r.command        = c;
      r.target_slot    = SLOT_W'(s);
      r.write_sequence = q;
      r.newest_found   = nv;
      r.recent_slot    = nv ? SLOT_W'(ni) : '0;
      r.write_pending  = pend;
      r.last           = 1'b1;
      return r;
   endfunction

   always_comb begin
      logic             do_deferred;
      logic             do_save;
      logic             found;
      logic [IDX_W-1:0] first_free;
      logic [IDX_W-1:0] scan_idx;
      rsp_type          prog_rsp;

      slot_used_in     = slot_used_ff;
      newest_valid_in  = newest_valid_ff;
      newest_index_in  = newest_index_ff;
      newest_seq_in    = newest_seq_ff;
      current_seq_in   = current_seq_ff;
      save_waiting_in  = save_waiting_ff;
      erase_waiting_in = erase_waiting_ff;
      elapsed_ms_in    = elapsed_ms_ff;
      do_deferred      = 1'b0;
      do_save          = 1'b0;
      found            = 1'b0;
      first_free       = '0;
      scan_idx         = IDX_W'(scan_slot);
      prog_rsp         = '0;
      batch            = '0;

      unique case (opcode)
         OP_INIT: begin
            slot_used_in     = '0;
            newest_valid_in  = 1'b0;
            newest_index_in  = '0;
            newest_seq_in    = '0;
            current_seq_in   = '0;
            save_waiting_in  = 1'b0;
            erase_waiting_in = 1'b0;
         end
         OP_SCAN: begin
            if (32'(scan_slot) < 32'(SLOT_COUNT)) begin
               slot_used_in[scan_idx] = (header_sequence != EMPTY_SEQ);
               if ((header_magic == valid_magic_ff) && (header_sequence != EMPTY_SEQ) &&
                   take_newest(newest_valid_ff, newest_index_ff, newest_seq_ff,
                               scan_idx, header_sequence)) begin
                  newest_valid_in = 1'b1;
                  newest_index_in = scan_idx;
                  newest_seq_in   = header_sequence;
                  current_seq_in  = header_sequence;
               end
            end
         end
         OP_TICK: begin
            if (elapsed_ms_ff != MS_MAX) begin
               elapsed_ms_in = elapsed_ms_ff + 1'b1;
            end
            if (erase_waiting_ff && !link_active) begin
               do_deferred = 1'b1;
            end else if (save_waiting_ff && (elapsed_ms_in >= debounce_ms_ff)) begin
               do_save = 1'b1;
            end
         end
         OP_SAVE_REQ: begin
            save_waiting_in = 1'b1;
            elapsed_ms_in   = '0;
         end
         OP_SAVE_NOW: begin
            do_save = 1'b1;
         end
         OP_DISCONNECT: begin
            do_deferred = erase_waiting_ff && !link_active;
         end
         OP_LOAD: begin
            if (newest_valid_ff) begin
               current_seq_in = newest_seq_ff;
            end
         end
         default: begin
         end
      endcase

      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            first_free = IDX_W'(i);
         end
      end
      found = ~&slot_used_ff;

      if (do_deferred) begin
         slot_used_in     = '0;
         newest_valid_in  = 1'b0;
         newest_index_in  = '0;
         newest_seq_in    = '0;
         erase_waiting_in = 1'b0;
         batch.first = make_rsp(CMD_ERASE, '0, '0, 1'b0, '0, save_waiting_ff);
         if (save_waiting_ff) begin
            current_seq_in  = current_seq_ff + 1'b1;
            slot_used_in[0] = 1'b1;
            newest_valid_in = 1'b1;
            newest_seq_in   = current_seq_in;
            save_waiting_in = 1'b0;
            batch.second = make_rsp(CMD_PROGRAM, '0, current_seq_in, 1'b1, '0, 1'b0);
            batch.two    = 1'b1;
         end
      end else if (do_save) begin
         current_seq_in = current_seq_ff + 1'b1;
         if (!found && link_active) begin
            erase_waiting_in = 1'b1;
            save_waiting_in  = 1'b1;
            batch.first = make_rsp(CMD_NONE, '0, '0, newest_valid_ff, newest_index_ff,
                                   1'b1);
         end else begin
            if (!found) begin
               slot_used_in     = '0;
               newest_valid_in  = 1'b0;
               newest_index_in  = '0;
               newest_seq_in    = '0;
               erase_waiting_in = 1'b0;
               first_free       = '0;
               batch.first = make_rsp(CMD_ERASE, '0, '0, 1'b0, '0, save_waiting_in);
               batch.two   = 1'b1;
            end
            slot_used_in[first_free] = 1'b1;
            if (take_newest(newest_valid_in, newest_index_in, newest_seq_in,
                            first_free, current_seq_in)) begin
               newest_valid_in = 1'b1;
               newest_index_in = first_free;
               newest_seq_in   = current_seq_in;
            end
            save_waiting_in = 1'b0;
            prog_rsp = make_rsp(CMD_PROGRAM, first_free, current_seq_in, newest_valid_in,
                                newest_index_in, erase_waiting_in);
            if (batch.two) begin
               batch.second = prog_rsp;
            end else begin
               batch.first = prog_rsp;
            end
         end
      end else begin
         batch.first = make_rsp(CMD_NONE, '0, '0, newest_valid_in, newest_index_in,
                                save_waiting_in || erase_waiting_in);
      end

      batch.first.last = !batch.two;
   end

   always_comb begin
      debounce_ms_in = debounce_ms_ff;
      valid_magic_in = valid_magic_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ms_in = csr_write_data[MS_W-1:0];
            CSR_MAGIC:    valid_magic_in = csr_write_data[MAGIC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff     <= '0;
         newest_valid_ff  <= 1'b0;
         newest_index_ff  <= '0;
         newest_seq_ff    <= '0;
         current_seq_ff   <= '0;
         save_waiting_ff  <= 1'b0;
         erase_waiting_ff <= 1'b0;
         elapsed_ms_ff    <= '0;
         debounce_ms_ff   <= RESET_DEBOUNCE;
         valid_magic_ff   <= RESET_MAGIC;
      end else begin
         debounce_ms_ff <= debounce_ms_in;
         valid_magic_ff <= valid_magic_in;
         if (fire) begin
            slot_used_ff     <= slot_used_in;
            newest_valid_ff  <= newest_valid_in;
            newest_index_ff  <= newest_index_in;
            newest_seq_ff    <= newest_seq_in;
            current_seq_ff   <= current_seq_in;
            save_waiting_ff  <= save_waiting_in;
            erase_waiting_ff <= erase_waiting_in;
            elapsed_ms_ff    <= elapsed_ms_in;
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/fjsm_rsp_buf.sv -----
// Two-entry result buffer that takes one or two results per transaction.
`default_nettype none
module fjsm_rsp_buf (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire fjsm_pkg::batch_type batch,
   output logic               room,
   input  wire logic          rsp_stall,
   output logic               rsp_valid,
   output fjsm_pkg::rsp_type  rsp
);
   import fjsm_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       pop;
   logic [1:0] cnt_after;
   logic [1:0] need;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp       = head_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign cnt_after = count_ff - {1'b0, pop};
   assign need      = batch.two ? 2'd2 : 2'd1;
   assign room      = ({1'b0, cnt_after} + {1'b0, need}) <= 3'd2;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = cnt_after;
      if (pop) begin
         head_in = tail_ff;
      end
      if (push) begin
         count_in = cnt_after + need;
         if (cnt_after == 2'd0) begin
            head_in = batch.first;
            tail_in = batch.second;
         end else begin
            tail_in = batch.first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule
`default_nettype wire

// ----- src/flash_journal_slot_manager_unit.sv -----
// Top level of the flash journal slot manager.
//
// Request channel (req_*): one transaction per operation (init, header scan,
// millisecond tick, save request, save now, link disconnect, load query).
// Response channel (rsp_*): one or two results per request, in order; the
// final one carries rsp_last. An erase result precedes the program result
// when the sector is full and the link is idle.
// Configuration (csr_*): index 0 debounce in ms, index 1 valid header magic.
// A request is registered in the request register, and its results are then
// registered in the response buffer, which drives rsp_*.
// Throughput: one request per cycle while rsp_stall is low and each request
// yields one result; a request with two results holds the port for both. The
// rate is set by the two-entry response buffer, with room for the whole batch.
// Reset clears the slot bitmap, newest record, sequence, pending flags and
// the debounce counter, and loads the register defaults.
// While rsp_stall is high, results hold in the buffer; once it cannot take a
// full batch, req_stall rises and the request register holds.
`default_nettype none
module flash_journal_slot_manager_unit #(
   parameter int SLOT_COUNT = fjsm_pkg::DEFAULT_SLOT_COUNT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [fjsm_pkg::OP_W-1:0]      req_opcode,
   input  wire logic                           req_link_active,
   input  wire logic [fjsm_pkg::SLOT_W-1:0]    req_scan_slot,
   input  wire logic [fjsm_pkg::MAGIC_W-1:0]   req_header_magic,
   input  wire logic [fjsm_pkg::SEQ_W-1:0]     req_header_sequence,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [fjsm_pkg::CMD_W-1:0]          rsp_command,
   output logic [fjsm_pkg::SLOT_W-1:0]         rsp_target_slot,
   output logic [fjsm_pkg::SEQ_W-1:0]          rsp_write_sequence,
   output logic                                rsp_newest_found,
   output logic [fjsm_pkg::SLOT_W-1:0]         rsp_newest_slot,
   output logic                                rsp_write_pending,
   output logic                                rsp_last,
   input  wire logic                           csr_write_enable,
   input  wire logic [fjsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fjsm_pkg::CSR_W-1:0]     csr_write_data
);
   import fjsm_pkg::*;

`include "flash_journal_slot_manager_unit_macros.svh"

   logic                req_valid_ff, req_valid_in;
   logic [OP_W-1:0]     opcode_ff;
   logic                link_active_ff;
   logic [SLOT_W-1:0]   scan_slot_ff;
   logic [MAGIC_W-1:0]  header_magic_ff;
   logic [SEQ_W-1:0]    header_sequence_ff;
   logic                accept;
   logic                room;
   logic                fire;
   batch_type           batch;
   rsp_type             rsp;

   assign fire      = req_valid_ff && room;
   assign req_stall = req_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff          <= req_opcode;
         link_active_ff     <= req_link_active;
         scan_slot_ff       <= req_scan_slot;
         header_magic_ff    <= req_header_magic;
         header_sequence_ff <= req_header_sequence;
      end
   end

   fjsm_core #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .opcode           (opcode_ff),
      .link_active      (link_active_ff),
      .scan_slot        (scan_slot_ff),
      .header_magic     (header_magic_ff),
      .header_sequence  (header_sequence_ff),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .batch            (batch)
   );

   fjsm_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .batch     (batch),
      .room      (room),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_command        = rsp.command;
   assign rsp_target_slot    = rsp.target_slot;
   assign rsp_write_sequence = rsp.write_sequence;
   assign rsp_newest_found   = rsp.newest_found;
   assign rsp_newest_slot    = rsp.recent_slot;
   assign rsp_write_pending  = rsp.write_pending;
   assign rsp_last           = rsp.last;

   `FJSM_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp_valid, "processed request left no result")
   `FJSM_ASSERT_NOW(a_pair_is_erase_program, batch.two,
      (batch.first.command == CMD_ERASE) && (batch.second.command == CMD_PROGRAM),
      "two-result batch is not erase then program")
   `FJSM_ASSERT_NOW(a_last_marks_end, 1'b1,
      (batch.first.last == !batch.two) && (!batch.two || batch.second.last),
      "last flag does not mark the final result")
   `FJSM_ASSERT_NOW(a_program_clears_pending, fire && (batch.first.command == CMD_PROGRAM),
      !batch.two, "program without erase reported as two results")

endmodule
`default_nettype wire
